@@ rtl/core/iso6709_pkg.sv @@
// Shared types, codes and digit helpers for the ISO 6709 coordinate parser.
package iso6709_pkg;

  // Parse position within one coordinate string
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_LAT   = 2'd1,
    PH_LON   = 2'd2
  } phase_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_NO_LON_SIGN = 3'd2,
    ST_BAD_LAT_LEN = 3'd3,
    ST_BAD_LON_LEN = 3'd4,
    ST_NON_DIGIT   = 3'd5
  } status_t;

  localparam int LAT_DEPTH     = 6;
  localparam int LON_DEPTH     = 7;
  localparam int LAT_COUNT_MAX = 7;
  localparam int LON_COUNT_MAX = 8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int LAT_W = 20;
  localparam int LON_W = 23;

  typedef logic [3:0] digit_t;

  // Two decimal digits to a value 0..99
  function automatic logic [6:0] pair_value(input digit_t hi, input digit_t lo);
    logic [6:0] v;
    v = 7'({hi, 3'b000}) + 7'({hi, 1'b0}) + 7'(lo);
    return v;
  endfunction

endpackage

@@ rtl/core/iso6709_coordinate_parser_core.sv @@
// Streaming ISO 6709 (zone.tab style) coordinate parser, top level.
//
// One ASCII byte per request enters on in_*; a NUL byte closes the string and
// yields one result on out_* with latitude and longitude in signed whole
// arc-seconds and a status code (0 ok, 1 empty, 2 no longitude sign, 3 bad
// latitude length, 4 bad longitude length, 5 non-digit); on any error both
// coordinates read zero. The block takes one byte every cycle: each byte is held
// in the input register, then the parse state updates, and a NUL forms the
// result in the same cycle that loads the output register, from which the
// result is presented on out_*. Only a NUL waits on a full, stalled output
// register; other bytes keep flowing.
module iso6709_coordinate_parser_core
  import iso6709_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [19:0] latitude_arcsec, [42:20] longitude_arcsec, zero pad
  output logic [2:0]  out_tuser   // [2:0] status
);

  // Input register
  logic       in_valid_r;
  logic [7:0] char_r;

  // Parse state
  phase_t      phase_r, phase_nxt;
  logic        lat_neg_r, lat_neg_nxt;
  logic        lon_neg_r, lon_neg_nxt;
  logic [2:0]  lat_cnt_r, lat_cnt_nxt;
  logic [3:0]  lon_cnt_r, lon_cnt_nxt;
  logic        bad_seen_r, bad_seen_nxt;
  digit_t      lat_dig_r [LAT_DEPTH];
  digit_t      lon_dig_r [LON_DEPTH];

  // Output register
  logic                    out_valid_r;
  logic signed [LAT_W-1:0] lat_out_r;
  logic signed [LON_W-1:0] lon_out_r;
  status_t                 status_r;

  logic    out_free, advance, is_nul, is_digit, is_sign;
  digit_t  dig_val;
  logic    lat_wr, lon_wr;
  status_t status_c;

  logic [6:0]  lat_deg, lat_min, lat_sec, lon_min, lon_sec;
  logic [9:0]  lon_deg;
  logic [18:0] lat_mag;
  logic [21:0] lon_mag;
  logic signed [LAT_W-1:0] lat_val;
  logic signed [LON_W-1:0] lon_val;

  // Handshake
  assign out_free  = !out_valid_r || out_tready;
  assign is_nul    = (char_r == CH_NUL);
  assign advance   = in_valid_r && (!is_nul || out_free);
  assign in_tready = !in_valid_r || advance;

  // Character classes
  assign is_digit = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
  assign is_sign  = (char_r == CH_PLUS) || (char_r == CH_MINUS);
  assign dig_val  = is_digit ? 4'(char_r - CH_ZERO) : 4'd0;

  // Next parse state and digit store writes
  always_comb begin
    phase_nxt    = phase_r;
    lat_neg_nxt  = lat_neg_r;
    lon_neg_nxt  = lon_neg_r;
    lat_cnt_nxt  = lat_cnt_r;
    lon_cnt_nxt  = lon_cnt_r;
    bad_seen_nxt = bad_seen_r;
    lat_wr       = 1'b0;
    lon_wr       = 1'b0;
    if (is_nul) begin
      phase_nxt    = PH_START;
      lat_neg_nxt  = 1'b0;
      lon_neg_nxt  = 1'b0;
      lat_cnt_nxt  = '0;
      lon_cnt_nxt  = '0;
      bad_seen_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_LAT: begin
          if (is_sign) begin
            lon_neg_nxt = (char_r == CH_MINUS);
            phase_nxt   = PH_LON;
          end else begin
            if (!is_digit) bad_seen_nxt = 1'b1;
            lat_wr = (lat_cnt_r < 3'(LAT_DEPTH));
            if (lat_cnt_r < 3'(LAT_COUNT_MAX)) lat_cnt_nxt = lat_cnt_r + 3'd1;
          end
        end
        PH_LON: begin
          if (!is_digit) bad_seen_nxt = 1'b1;
          lon_wr = (lon_cnt_r < 4'(LON_DEPTH));
          if (lon_cnt_r < 4'(LON_COUNT_MAX)) lon_cnt_nxt = lon_cnt_r + 4'd1;
        end
        default: begin
          // first byte is the latitude sign, whatever it is
          lat_neg_nxt = (char_r == CH_MINUS);
          phase_nxt   = PH_LAT;
        end
      endcase
    end
  end

  // Status priority on end of string
  always_comb begin
    if (phase_r != PH_LAT && phase_r != PH_LON)   status_c = ST_EMPTY;
    else if (phase_r == PH_LAT)                   status_c = ST_NO_LON_SIGN;
    else if (lat_cnt_r != 3'd4 && lat_cnt_r != 3'd6) status_c = ST_BAD_LAT_LEN;
    else if (lon_cnt_r != 4'd5 && lon_cnt_r != 4'd7) status_c = ST_BAD_LON_LEN;
    else if (bad_seen_r)                          status_c = ST_NON_DIGIT;
    else                                          status_c = ST_OK;
  end

  // Arc-second conversion
  always_comb begin
    lat_deg = pair_value(lat_dig_r[0], lat_dig_r[1]);
    lat_min = pair_value(lat_dig_r[2], lat_dig_r[3]);
    lat_sec = (lat_cnt_r == 3'd6) ? pair_value(lat_dig_r[4], lat_dig_r[5]) : 7'd0;
    lon_deg = 10'(lon_dig_r[0]) * 10'd100 + 10'(lon_dig_r[1]) * 10'd10
            + 10'(lon_dig_r[2]);
    lon_min = pair_value(lon_dig_r[3], lon_dig_r[4]);
    lon_sec = (lon_cnt_r == 4'd7) ? pair_value(lon_dig_r[5], lon_dig_r[6]) : 7'd0;
    lat_mag = 19'(lat_deg) * 19'd3600 + 19'(lat_min) * 19'd60 + 19'(lat_sec);
    lon_mag = 22'(lon_deg) * 22'd3600 + 22'(lon_min) * 22'd60 + 22'(lon_sec);
    lat_val = lat_neg_r ? -$signed({1'b0, lat_mag}) : $signed({1'b0, lat_mag});
    lon_val = lon_neg_r ? -$signed({1'b0, lon_mag}) : $signed({1'b0, lon_mag});
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) char_r <= in_tdata;
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      lat_neg_r  <= 1'b0;
      lon_neg_r  <= 1'b0;
      lat_cnt_r  <= '0;
      lon_cnt_r  <= '0;
      bad_seen_r <= 1'b0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      lat_neg_r  <= lat_neg_nxt;
      lon_neg_r  <= lon_neg_nxt;
      lat_cnt_r  <= lat_cnt_nxt;
      lon_cnt_r  <= lon_cnt_nxt;
      bad_seen_r <= bad_seen_nxt;
    end
  end

  // Digit stores, no reset
  always_ff @(posedge clk) begin
    if (advance && lat_wr) lat_dig_r[lat_cnt_r] <= dig_val;
    if (advance && lon_wr) lon_dig_r[lon_cnt_r[2:0]] <= dig_val;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && is_nul) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && is_nul) begin
      status_r  <= status_c;
      lat_out_r <= (status_c == ST_OK) ? lat_val : '0;
      lon_out_r <= (status_c == ST_OK) ? lon_val : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, lon_out_r, lat_out_r};
  assign out_tuser  = status_r;

  // An error result carries zero coordinates
  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_OK |-> lat_out_r == '0 && lon_out_r == '0)
    else $error("error result with nonzero coordinates");

  // A taken NUL produces a result and rewinds the parser
  a_nul_result : assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_nul |=> out_valid_r && phase_r == PH_START)
    else $error("NUL did not produce a result or rewind");

  // At the start of a string all per-string state is clear
  a_start_clear : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_START |-> lat_cnt_r == '0 && lon_cnt_r == '0 && !bad_seen_r
                            && !lat_neg_r && !lon_neg_r)
    else $error("stale string state at start");

endmodule
